// File: rtl/cfd_pkg.sv
// package for the crc-32 frame decoder: sizes, magic, verdict codes and crc step
package cfd_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int COUNT_BITS   = 33;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // magic "SQDP", byte 0 in the low lane
   localparam logic [31:0] MAGIC_WORD = {8'h50, 8'h44, 8'h51, 8'h53};

   // header byte offsets
   localparam int KIND_POS     = 4;
   localparam int OPCODE_POS   = 5;
   localparam int STATUS_POS   = 6;
   localparam int SEQUENCE_POS = 8;
   localparam int LENGTH_POS   = 12;
   localparam int CRC_POS      = 16;

   typedef enum logic [2:0] {
      RESULT_OK         = 3'd0,
      RESULT_TRUNCATED  = 3'd1,
      RESULT_BAD_MAGIC  = 3'd2,
      RESULT_BAD_LENGTH = 3'd3,
      RESULT_BAD_CRC    = 3'd4
   } result_code_type;

   // one byte of the reflected crc-32, eight bit steps unrolled
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: rtl/cfd_req_if.sv
// byte channel into the frame decoder
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_frame;

   modport source (output valid, output data_byte, output end_of_frame, input ready);
   modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

// File: rtl/cfd_rsp_if.sv
// verdict channel out of the frame decoder
interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_code;
   logic [7:0]  frame_kind;
   logic [7:0]  frame_opcode;
   logic [7:0]  frame_status;
   logic [31:0] sequence_number;
   logic [31:0] payload_length;
   logic [31:0] frame_crc;

   modport source (output valid, output result_code, output frame_kind, output frame_opcode,
                   output frame_status, output sequence_number, output payload_length,
                   output frame_crc, input ready);
   modport sink   (input valid, input result_code, input frame_kind, input frame_opcode,
                   input frame_status, input sequence_number, input payload_length,
                   input frame_crc, output ready);
endinterface

// File: rtl/crc32_frame_decoder.sv
// frame decoder top level: header capture, payload crc-32 and end-of-frame verdict
//
// takes one frame byte per cycle on req_ch, last byte flagged by end_of_frame. bytes 0..3
// must read "SQDP", bytes 4..6 give kind, opcode and status, byte 7 is skipped, bytes 8..19
// carry little-endian sequence, payload length and payload crc, and every later byte runs
// through a reflected crc-32 (poly edb88320, init all ones, final inversion), one whole byte
// per cycle. on the flagged byte a single verdict item appears on rsp_ch in the next cycle:
// truncated header, bad magic, length mismatch, crc mismatch or ok, first failing check
// winning, with the header fields shown only on ok and zero otherwise. the decoder then
// starts afresh for the next frame. a new byte is taken every cycle; req_ch.ready drops
// only while a verdict sits in the output register and rsp_ch.ready is low. the byte count
// saturates, so very long frames report a length mismatch.
module crc32_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   cfd_req_if.sink     req_ch,
   cfd_rsp_if.source   rsp_ch
);

   localparam int CB = cfd_pkg::COUNT_BITS;

   // frame state
   logic [CB-1:0] count_ff, count_in;
   logic [31:0]   crc_ff, crc_in;
   logic          magic_ff, magic_in;
   logic [7:0]    kind_ff, kind_in;
   logic [7:0]    opcode_ff, opcode_in;
   logic [7:0]    status_ff, status_in;
   logic [31:0]   sequence_ff, sequence_in;
   logic [31:0]   length_ff, length_in;
   logic [31:0]   expected_ff, expected_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   cfd_pkg::result_code_type code_ff, code_in;
   logic [7:0]    out_kind_ff, out_kind_in;
   logic [7:0]    out_opcode_ff, out_opcode_in;
   logic [7:0]    out_status_ff, out_status_in;
   logic [31:0]   out_sequence_ff, out_sequence_in;
   logic [31:0]   out_length_ff, out_length_in;
   logic [31:0]   out_crc_ff, out_crc_in;

   logic          accept;
   logic          in_header;
   logic [4:0]    pos;
   logic [4:0]    lane_shift;
   logic [31:0]   lane_mask;
   logic [31:0]   lane_byte;
   logic [CB-1:0] expected_total;
   cfd_pkg::result_code_type verdict;

   // stall only while a verdict waits untaken
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // header position decode, count below twenty fits five bits
   assign in_header  = (count_ff < CB'(cfd_pkg::HEADER_BYTES));
   assign pos        = count_ff[4:0];
   assign lane_shift = {pos[1:0], 3'b000};
   assign lane_mask  = ~(32'h0000_00FF << lane_shift);
   assign lane_byte  = {24'd0, req_ch.data_byte} << lane_shift;

   always_comb begin
      crc_in      = crc_ff;
      magic_in    = magic_ff;
      kind_in     = kind_ff;
      opcode_in   = opcode_ff;
      status_in   = status_ff;
      sequence_in = sequence_ff;
      length_in   = length_ff;
      expected_in = expected_ff;

      // route the byte by its place in the frame
      if (!in_header) begin
         crc_in = cfd_pkg::crc_byte(crc_ff, req_ch.data_byte);
      end else if (pos < 5'(cfd_pkg::KIND_POS)) begin
         if (req_ch.data_byte != cfd_pkg::MAGIC_WORD[lane_shift +: 8]) begin
            magic_in = 1'b0;
         end
      end else if (pos == 5'(cfd_pkg::KIND_POS)) begin
         kind_in = req_ch.data_byte;
      end else if (pos == 5'(cfd_pkg::OPCODE_POS)) begin
         opcode_in = req_ch.data_byte;
      end else if (pos == 5'(cfd_pkg::STATUS_POS)) begin
         status_in = req_ch.data_byte;
      end else if (pos >= 5'(cfd_pkg::SEQUENCE_POS) && pos < 5'(cfd_pkg::LENGTH_POS)) begin
         sequence_in = (sequence_ff & lane_mask) | lane_byte;
      end else if (pos >= 5'(cfd_pkg::LENGTH_POS) && pos < 5'(cfd_pkg::CRC_POS)) begin
         length_in = (length_ff & lane_mask) | lane_byte;
      end else if (pos >= 5'(cfd_pkg::CRC_POS)) begin
         expected_in = (expected_ff & lane_mask) | lane_byte;
      end

      // saturating byte count
      count_in = (count_ff == cfd_pkg::COUNT_MAX) ? count_ff : count_ff + CB'(1);
   end

   // verdict on the updated state, first failing check wins
   assign expected_total = {1'b0, length_in} + CB'(cfd_pkg::HEADER_BYTES);

   always_comb begin
      if (count_in < CB'(cfd_pkg::HEADER_BYTES)) begin
         verdict = cfd_pkg::RESULT_TRUNCATED;
      end else if (!magic_in) begin
         verdict = cfd_pkg::RESULT_BAD_MAGIC;
      end else if (count_in != expected_total) begin
         verdict = cfd_pkg::RESULT_BAD_LENGTH;
      end else if (~crc_in != expected_in) begin
         verdict = cfd_pkg::RESULT_BAD_CRC;
      end else begin
         verdict = cfd_pkg::RESULT_OK;
      end
   end

   // output register loads on the last byte of a frame
   always_comb begin
      out_valid_in    = out_valid_ff && !rsp_ch.ready;
      code_in         = code_ff;
      out_kind_in     = out_kind_ff;
      out_opcode_in   = out_opcode_ff;
      out_status_in   = out_status_ff;
      out_sequence_in = out_sequence_ff;
      out_length_in   = out_length_ff;
      out_crc_in      = out_crc_ff;
      if (accept && req_ch.end_of_frame) begin
         out_valid_in = 1'b1;
         code_in      = verdict;
         if (verdict == cfd_pkg::RESULT_OK) begin
            out_kind_in     = kind_in;
            out_opcode_in   = opcode_in;
            out_status_in   = status_in;
            out_sequence_in = sequence_in;
            out_length_in   = length_in;
            out_crc_in      = expected_in;
         end else begin
            out_kind_in     = '0;
            out_opcode_in   = '0;
            out_status_in   = '0;
            out_sequence_in = '0;
            out_length_in   = '0;
            out_crc_in      = '0;
         end
      end
   end

   // frame state, cleared after each verdict
   always_ff @(posedge clock) begin
      if (reset || (accept && req_ch.end_of_frame)) begin
         count_ff    <= '0;
         crc_ff      <= cfd_pkg::CRC_INIT;
         magic_ff    <= 1'b1;
         kind_ff     <= '0;
         opcode_ff   <= '0;
         status_ff   <= '0;
         sequence_ff <= '0;
         length_ff   <= '0;
         expected_ff <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         magic_ff    <= magic_in;
         kind_ff     <= kind_in;
         opcode_ff   <= opcode_in;
         status_ff   <= status_in;
         sequence_ff <= sequence_in;
         length_ff   <= length_in;
         expected_ff <= expected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the output register, no reset needed
   always_ff @(posedge clock) begin
      code_ff         <= code_in;
      out_kind_ff     <= out_kind_in;
      out_opcode_ff   <= out_opcode_in;
      out_status_ff   <= out_status_in;
      out_sequence_ff <= out_sequence_in;
      out_length_ff   <= out_length_in;
      out_crc_ff      <= out_crc_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.result_code     = code_ff;
   assign rsp_ch.frame_kind      = out_kind_ff;
   assign rsp_ch.frame_opcode    = out_opcode_ff;
   assign rsp_ch.frame_status    = out_status_ff;
   assign rsp_ch.sequence_number = out_sequence_ff;
   assign rsp_ch.payload_length  = out_length_ff;
   assign rsp_ch.frame_crc       = out_crc_ff;

endmodule

// File: test/tb_crc32_frame_decoder.sv
// testbench for the crc-32 frame decoder: directed and random frames against a scoreboard
`timescale 1ns / 100ps

module tb_crc32_frame_decoder;

   localparam int CB             = cfd_pkg::COUNT_BITS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_BYTES    = 80;
   localparam int PHASE_FRAMES   = 3;

   // one verdict as seen on the result channel
   typedef struct packed {
      cfd_pkg::result_code_type code;
      logic [7:0]      kind;
      logic [7:0]      opcode;
      logic [7:0]      status;
      logic [31:0]     sequence_number;
      logic [31:0]     payload_length;
      logic [31:0]     frame_crc;
   } verdict_type;

   typedef logic [7:0] byte_queue_type[$];

   // mirrors the decoder state byte by byte and queues the verdict each frame should give
   class verdict_board;
      logic [CB-1:0]         seen;
      logic [31:0]           crc_run;
      bit                    magic_ok;
      logic [7:0]            kind_q, opcode_q, status_q;
      logic [31:0]           seq_q, len_q, crc_q;
      verdict_type           expected_q[$];
      int unsigned           mismatches;
      int unsigned           checked;
      int unsigned           code_tally[5];

      function new();
         clear();
         mismatches = 0;
         checked    = 0;
         foreach (code_tally[i]) code_tally[i] = 0;
      endfunction

      function void clear();
         seen     = '0;
         crc_run  = cfd_pkg::CRC_INIT;
         magic_ok = 1'b1;
         kind_q   = '0;
         opcode_q = '0;
         status_q = '0;
         seq_q    = '0;
         len_q    = '0;
         crc_q    = '0;
      endfunction

      // bit-serial reflected crc, lsb of the byte first
      static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ cfd_pkg::CRC_POLY;
         end
         return c;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [CB-1:0] pos;
         verdict_type   v;
         pos = seen;
         if (pos < 4) begin
            if (b != cfd_pkg::MAGIC_WORD[8*pos[1:0] +: 8]) magic_ok = 1'b0;
         end else if (pos == cfd_pkg::KIND_POS) begin
            kind_q = b;
         end else if (pos == cfd_pkg::OPCODE_POS) begin
            opcode_q = b;
         end else if (pos == cfd_pkg::STATUS_POS) begin
            status_q = b;
         end else if (pos >= cfd_pkg::SEQUENCE_POS && pos < cfd_pkg::LENGTH_POS) begin
            seq_q[8*pos[1:0] +: 8] = b;
         end else if (pos >= cfd_pkg::LENGTH_POS && pos < cfd_pkg::CRC_POS) begin
            len_q[8*pos[1:0] +: 8] = b;
         end else if (pos >= cfd_pkg::CRC_POS && pos < cfd_pkg::HEADER_BYTES) begin
            crc_q[8*pos[1:0] +: 8] = b;
         end else if (pos >= cfd_pkg::HEADER_BYTES) begin
            crc_run = crc_step(crc_run, b);
         end
         if (pos != cfd_pkg::COUNT_MAX) seen = pos + 1'b1;
         if (!last) return;
         v = '0;
         if (seen < cfd_pkg::HEADER_BYTES) v.code = cfd_pkg::RESULT_TRUNCATED;
         else if (!magic_ok) v.code = cfd_pkg::RESULT_BAD_MAGIC;
         else if (seen != CB'(cfd_pkg::HEADER_BYTES) + {1'b0, len_q})
            v.code = cfd_pkg::RESULT_BAD_LENGTH;
         else if (~crc_run != crc_q) v.code = cfd_pkg::RESULT_BAD_CRC;
         else begin
            v.code            = cfd_pkg::RESULT_OK;
            v.kind            = kind_q;
            v.opcode          = opcode_q;
            v.status          = status_q;
            v.sequence_number = seq_q;
            v.payload_length  = len_q;
            v.frame_crc       = crc_q;
         end
         expected_q.push_back(v);
         clear();
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: verdict with none expected, expected nothing, actual code %0d",
                     $time, got.code);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.code <= cfd_pkg::RESULT_BAD_CRC) code_tally[want.code]++;
         compare("result_code", 32'(want.code), 32'(got.code));
         compare("frame_kind", 32'(want.kind), 32'(got.kind));
         compare("frame_opcode", 32'(want.opcode), 32'(got.opcode));
         compare("frame_status", 32'(want.status), 32'(got.status));
         compare("sequence_number", want.sequence_number, got.sequence_number);
         compare("payload_length", want.payload_length, got.payload_length);
         compare("frame_crc", want.frame_crc, got.frame_crc);
      endfunction
   endclass

   logic clock;
   logic reset;

   cfd_req_if req_ch ();
   cfd_rsp_if rsp_ch ();

   crc32_frame_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   verdict_board board = new();

   // idling odds in percent, changed per phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned bytes_sent     = 0;
   int unsigned frames_sent    = 0;
   int unsigned idle_run       = 0;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: ready rolled afresh at every falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // sample both channels at the rising edge; the watchdog counts cycles with no item moving
   always @(posedge clock) begin : monitor
      verdict_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_byte(req_ch.data_byte, req_ch.end_of_frame);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.code            = cfd_pkg::result_code_type'(rsp_ch.result_code);
            got.kind            = rsp_ch.frame_kind;
            got.opcode          = rsp_ch.frame_opcode;
            got.status          = rsp_ch.frame_status;
            got.sequence_number = rsp_ch.sequence_number;
            got.payload_length  = rsp_ch.payload_length;
            got.frame_crc       = rsp_ch.frame_crc;
            board.check_verdict(got);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_run = 0;
         else
            idle_run++;
         if (idle_run == WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("crc32_frame_decoder regression: fail");
            $finish;
         end
      end
   end

   // one byte: optional idle cycles, then hold valid until the decoder takes it
   // entered and left at a falling edge with nothing yet driven in that step
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.end_of_frame <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input byte_queue_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
      frames_sent++;
   endtask

   // sender goes quiet until every verdict is back, then a short hold-off
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_word(ref byte_queue_type f, input int pos, input logic [31:0] w);
      for (int i = 0; i < 4; i++) f[pos+i] = w[8*i +: 8];
   endtask

   // well-formed frame; header fill 0 random, 1 all zero, 2 all ones (length and crc are real)
   task automatic make_frame(input int fill, input int unsigned pay_n,
                             output byte_queue_type f);
      logic [7:0]  payload[$];
      logic [31:0] crc;
      logic [31:0] len;
      f   = {};
      crc = cfd_pkg::CRC_INIT;
      len = pay_n;
      for (int i = 0; i < int'(pay_n); i++) payload.push_back(8'($urandom));
      foreach (payload[i]) crc = verdict_board::crc_step(crc, payload[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) f.push_back(cfd_pkg::MAGIC_WORD[8*i +: 8]);
      // kind, opcode, status, the skipped byte and the sequence number
      for (int i = cfd_pkg::KIND_POS; i < cfd_pkg::LENGTH_POS; i++)
         f.push_back(fill == 0 ? 8'($urandom) : (fill == 1 ? 8'h00 : 8'hFF));
      for (int i = 0; i < 4; i++) f.push_back(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) f.push_back(crc[8*i +: 8]);
      foreach (payload[i]) f.push_back(payload[i]);
   endtask

   // mostly good frames with random content, the rest broken in one way or plain noise
   task automatic send_random_frame();
      byte_queue_type f;
      int unsigned    pick;
      int unsigned    pay_n;
      logic [31:0]    w;
      int unsigned    n;
      pick  = $urandom_range(99);
      pay_n = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(8);
      make_frame(0, pay_n, f);
      if (pick >= 65 && pick < 72) begin
         // one bit of the magic wrong
         n = $urandom_range(3);
         f[n] = f[n] ^ (8'h01 << $urandom_range(7));
      end else if (pick >= 72 && pick < 80) begin
         // declared length near the real one, or anywhere in 32 bits
         if ($urandom_range(1) == 0) w = pay_n + $urandom_range(1, 3);
         else if ($urandom_range(1) == 0) w = pay_n - $urandom_range(1, 3);
         else w = $urandom;
         if (w == pay_n) w = w ^ 32'h1;
         set_word(f, cfd_pkg::LENGTH_POS, w);
      end else if (pick >= 80 && pick < 88) begin
         w = {f[cfd_pkg::CRC_POS+3], f[cfd_pkg::CRC_POS+2],
              f[cfd_pkg::CRC_POS+1], f[cfd_pkg::CRC_POS]};
         w = w ^ (32'h1 << $urandom_range(31));
         set_word(f, cfd_pkg::CRC_POS, w);
      end else if (pick >= 88 && pick < 95) begin
         n = $urandom_range(1, cfd_pkg::HEADER_BYTES - 1);
         while (f.size() > n) void'(f.pop_back());
      end else if (pick >= 95) begin
         f = {};
         n = $urandom_range(1, 40);
         repeat (n) f.push_back(8'($urandom));
      end
      send_frame(f);
   endtask

   initial begin : stimulus
      byte_queue_type f;
      int unsigned    phase_start_bytes;
      int unsigned    phase_start_frames;

      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.end_of_frame = 1'b0;
      reset               = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single marked byte: truncated
      f = {8'h53};
      send_frame(f);
      // one byte short of a full header, magic good
      make_frame(2, 0, f);
      void'(f.pop_back());
      send_frame(f);
      // header only, fields all ones
      make_frame(2, 0, f);
      send_frame(f);
      // one payload byte, fields all zero
      make_frame(1, 1, f);
      send_frame(f);
      make_frame(2, 5, f);
      send_frame(f);
      // bad magic on the first byte
      make_frame(0, 2, f);
      f[0] = 8'h00;
      send_frame(f);
      // bad magic wins over a bad length
      make_frame(0, 1, f);
      f[3] = f[3] ^ 8'h80;
      set_word(f, cfd_pkg::LENGTH_POS, 32'd7);
      send_frame(f);
      // surplus payload past the declared length
      make_frame(0, 3, f);
      set_word(f, cfd_pkg::LENGTH_POS, 32'd1);
      send_frame(f);
      // largest declared length with no payload
      make_frame(2, 0, f);
      set_word(f, cfd_pkg::LENGTH_POS, 32'hFFFF_FFFF);
      send_frame(f);
      // payload crc off by one bit
      make_frame(2, 4, f);
      f[cfd_pkg::CRC_POS] = f[cfd_pkg::CRC_POS] ^ 8'h01;
      send_frame(f);
      // short frame wins over a bad magic
      f = {8'h00, 8'hFF, 8'h44};
      send_frame(f);

      // hold the sender off until all verdicts are in
      wait_drained();

      // a saturated byte count needs 2^33 - 1 bytes, out of reach in simulation
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         phase_start_bytes  = bytes_sent;
         phase_start_frames = frames_sent;
         while (bytes_sent - phase_start_bytes < PHASE_BYTES ||
                frames_sent - phase_start_frames < PHASE_FRAMES)
            send_random_frame();
         wait_drained();
      end

      recv_stall_pct = 0;
      repeat (10) @(negedge clock);

      $display("covered %0d frames, %0d bytes, over four idling phases; %0d verdicts checked",
               frames_sent, bytes_sent, board.checked);
      $display("verdicts: ok %0d, truncated %0d, bad magic %0d, bad length %0d, bad crc %0d",
               board.code_tally[cfd_pkg::RESULT_OK],
               board.code_tally[cfd_pkg::RESULT_TRUNCATED],
               board.code_tally[cfd_pkg::RESULT_BAD_MAGIC],
               board.code_tally[cfd_pkg::RESULT_BAD_LENGTH],
               board.code_tally[cfd_pkg::RESULT_BAD_CRC]);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("crc32_frame_decoder regression: pass");
      end else begin
         if (board.pending() != 0)
            $display("%0t: %0d verdicts never arrived", $time, board.pending());
         $display("crc32_frame_decoder regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cfd_pkg.sv
rtl/cfd_req_if.sv
rtl/cfd_rsp_if.sv
rtl/crc32_frame_decoder.sv
test/tb_crc32_frame_decoder.sv
